[hw/rtl/sfar_pkg.sv]
package sfar_pkg;

	// opacity is held in twentieths of full
	localparam int unsigned ALPHA_W = 5;
	localparam logic [ALPHA_W-1:0] ALPHA_FULL = 5'd20;

	localparam int unsigned COLOR_W    = 8;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned INTERVAL_W = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [2:0] {
		MODE_NONE   = 3'd0,
		MODE_IN     = 3'd1,
		MODE_OUT    = 3'd2,
		MODE_OUT_IN = 3'd3,
		MODE_FLASH  = 3'd4
	} fade_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FADE_MODE = 3'd0,
		REG_RED       = 3'd1,
		REG_GREEN     = 3'd2,
		REG_BLUE      = 3'd3,
		REG_INTERVAL  = 3'd4
	} cfg_reg_t;

endpackage

[hw/rtl/screen_fade_alpha_ramp.sv]
// Timed overlay fade controller. Every request on the input channel yields exactly one
// result: a start request (command = 1) latches the configured mode, colour and step
// interval, sets the starting opacity and clears the step deadline; a tick request
// (command = 0) carries the current time in ms and, once that time is strictly past the
// deadline, reloads the deadline and moves the opacity one step. Opacity runs 0..20 in
// twentieths of full. Modes: fade in, fade out, out then in, and flash (white up by 5 on
// a 5 ms reload, white down by 1, then black up by 1). The result carries opacity,
// colour and an active flag. The state registers double as the result register: the
// compare against the deadline, two 32-bit adds for the reloads and a saturating
// opacity step sit in front of them. A new request is taken every cycle as long as
// the previous result is taken in the same cycle or has already gone; a result is
// valid in the cycle after its request is accepted. Registers are written on the
// configuration channel (always ready) and must only change while the block is idle.
module screen_fade_alpha_ramp
	import sfar_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic [TIME_W-1:0]     now_ms,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ALPHA_W-1:0]    alpha_level,
	output logic [COLOR_W-1:0]    out_red,
	output logic [COLOR_W-1:0]    out_green,
	output logic [COLOR_W-1:0]    out_blue,
	output logic                  fade_active
);

	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;

	localparam logic [INTERVAL_W-1:0] FLASH_RELOAD_MS = 16'd5;
	localparam logic [COLOR_W-1:0]    COLOR_WHITE     = 8'hFF;
	localparam logic [COLOR_W-1:0]    COLOR_BLACK     = 8'h00;

	// configuration registers
	fade_mode_t            cfg_mode_q;
	logic [COLOR_W-1:0]    cfg_red_q, cfg_green_q, cfg_blue_q;
	logic [INTERVAL_W-1:0] cfg_interval_q;

	// fade state; opacity, colour and running flag also form the result
	fade_mode_t            mode_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic [ALPHA_W-1:0]    alpha_q;
	logic [COLOR_W-1:0]    red_q, green_q, blue_q;
	logic                  running_q;
	logic [TIME_W-1:0]     deadline_q;
	logic [1:0]            phase_q;
	logic                  out_valid_q;

	fade_mode_t            mode_d;
	logic [INTERVAL_W-1:0] interval_d;
	logic [ALPHA_W-1:0]    alpha_d;
	logic [COLOR_W-1:0]    red_d, green_d, blue_d;
	logic                  running_d;
	logic [TIME_W-1:0]     deadline_d;
	logic [1:0]            phase_d;

	logic                  in_acc;
	logic                  step_due;
	logic [TIME_W-1:0]     reload_ms;
	logic [TIME_W-1:0]     flash_reload_ms;

	function automatic logic [ALPHA_W-1:0] alpha_up(input logic [ALPHA_W-1:0] a,
			input logic [ALPHA_W-1:0] d);
		logic [ALPHA_W:0] s;
		s = {1'b0, a} + {1'b0, d};
		return (s > {1'b0, ALPHA_FULL}) ? ALPHA_FULL : s[ALPHA_W-1:0];
	endfunction

	function automatic logic [ALPHA_W-1:0] alpha_down(input logic [ALPHA_W-1:0] a,
			input logic [ALPHA_W-1:0] d);
		return (a > d) ? a - d : '0;
	endfunction

	assign cfg_ready = 1'b1;

	// take a new request while the result slot is empty or draining
	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	assign step_due        = running_q && (now_ms > deadline_q);
	assign reload_ms       = now_ms + {{(TIME_W-INTERVAL_W){1'b0}}, interval_q};
	assign flash_reload_ms = now_ms + {{(TIME_W-INTERVAL_W){1'b0}}, FLASH_RELOAD_MS};

	always_comb begin
		mode_d     = mode_q;
		interval_d = interval_q;
		alpha_d    = alpha_q;
		red_d      = red_q;
		green_d    = green_q;
		blue_d     = blue_q;
		running_d  = running_q;
		deadline_d = deadline_q;
		phase_d    = phase_q;

		if (command) begin
			// start: latch the set-up, no step taken on this request
			mode_d     = cfg_mode_q;
			interval_d = cfg_interval_q;
			red_d      = cfg_red_q;
			green_d    = cfg_green_q;
			blue_d     = cfg_blue_q;
			running_d  = 1'b1;
			deadline_d = '0;
			phase_d    = PH_FIRST;
			unique case (cfg_mode_q)
				MODE_IN, MODE_FLASH: alpha_d = '0;
				MODE_OUT, MODE_OUT_IN: alpha_d = ALPHA_FULL;
				default: alpha_d = alpha_q;  // none and unused codes keep opacity
			endcase
		end else if (step_due) begin
			unique case (mode_q)
				MODE_IN: begin
					deadline_d = reload_ms;
					alpha_d    = alpha_up(alpha_q, 5'd2);
					if (alpha_d >= ALPHA_FULL) running_d = 1'b0;
				end
				MODE_OUT: begin
					deadline_d = reload_ms;
					alpha_d    = alpha_down(alpha_q, 5'd2);
					if (alpha_d == '0) running_d = 1'b0;
				end
				MODE_OUT_IN: begin
					deadline_d = reload_ms;
					// any phase past the first runs the upward leg
					if (phase_q == PH_FIRST) begin
						alpha_d = alpha_down(alpha_q, 5'd2);
						if (alpha_d == '0) phase_d = PH_SECOND;
					end else begin
						alpha_d = alpha_up(alpha_q, 5'd2);
						if (alpha_d >= ALPHA_FULL) running_d = 1'b0;
					end
				end
				MODE_FLASH: begin
					priority if (phase_q == PH_FIRST) begin
						red_d      = COLOR_WHITE;
						green_d    = COLOR_WHITE;
						blue_d     = COLOR_WHITE;
						deadline_d = flash_reload_ms;
						alpha_d    = alpha_up(alpha_q, 5'd5);
						if (alpha_d >= ALPHA_FULL) phase_d = PH_SECOND;
					end else if (phase_q == PH_SECOND) begin
						deadline_d = reload_ms;
						alpha_d    = alpha_down(alpha_q, 5'd1);
						if (alpha_d == '0) begin
							red_d   = COLOR_BLACK;
							green_d = COLOR_BLACK;
							blue_d  = COLOR_BLACK;
							phase_d = PH_THIRD;
						end else begin
							red_d   = COLOR_WHITE;
							green_d = COLOR_WHITE;
							blue_d  = COLOR_WHITE;
						end
					end else if (phase_q == PH_THIRD) begin
						deadline_d = reload_ms;
						alpha_d    = alpha_up(alpha_q, 5'd1);
						if (alpha_d >= ALPHA_FULL) running_d = 1'b0;
					end else begin
						// fourth phase never entered: hold everything
						alpha_d = alpha_q;
					end
				end
				default: begin
					// mode none or unused code: ticks change nothing
					alpha_d = alpha_q;
				end
			endcase
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mode_q     <= MODE_NONE;
			cfg_red_q      <= '0;
			cfg_green_q    <= '0;
			cfg_blue_q     <= '0;
			cfg_interval_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FADE_MODE: cfg_mode_q     <= fade_mode_t'(cfg_data[2:0]);
				REG_RED:       cfg_red_q      <= cfg_data[COLOR_W-1:0];
				REG_GREEN:     cfg_green_q    <= cfg_data[COLOR_W-1:0];
				REG_BLUE:      cfg_blue_q     <= cfg_data[COLOR_W-1:0];
				REG_INTERVAL:  cfg_interval_q <= cfg_data[INTERVAL_W-1:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// advance state on each accepted request; result valid follows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NONE;
			interval_q  <= '0;
			alpha_q     <= '0;
			red_q       <= '0;
			green_q     <= '0;
			blue_q      <= '0;
			running_q   <= 1'b0;
			deadline_q  <= '0;
			phase_q     <= PH_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				mode_q     <= mode_d;
				interval_q <= interval_d;
				alpha_q    <= alpha_d;
				red_q      <= red_d;
				green_q    <= green_d;
				blue_q     <= blue_d;
				running_q  <= running_d;
				deadline_q <= deadline_d;
				phase_q    <= phase_d;
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign alpha_level = alpha_q;
	assign out_red     = red_q;
	assign out_green   = green_q;
	assign out_blue    = blue_q;
	assign fade_active = running_q;

endmodule

[hw/rtl/sfar_checker.sv]
module sfar_checker
	import sfar_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [ALPHA_W-1:0] alpha_level,
	input logic [COLOR_W-1:0] out_red,
	input logic               fade_active
);

	// every accepted request leaves a result behind
	a_req_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted request produced no result");

	// a stalled result blocks the input side
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while result stalled");

	// opacity never leaves its range
	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> alpha_level <= ALPHA_FULL)
		else $error("opacity out of range");

	// a stalled result holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(alpha_level)
			&& $stable(out_red) && $stable(fade_active))
		else $error("stalled result changed");

endmodule

bind screen_fade_alpha_ramp sfar_checker u_sfar_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.alpha_level (alpha_level),
	.out_red     (out_red),
	.fade_active (fade_active)
);
